[hdl/min_key_priority_queue_top_macros.svh]
// Shared assertion macros for the priority queue checker.
`ifndef MIN_KEY_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MIN_KEY_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define MKPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define MKPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mkpq_pkg.sv]
package mkpq_pkg;

    // Operation codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_PUSH   = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] key_in;
        logic [31:0]        payload_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] key_out;
        logic [31:0]        payload_out;
        logic [4:0]         occupancy;
    } out_item_t;

    // Commands broadcast to every slot of the chain
    typedef struct packed {
        logic load;   // capture local compare into the scan flag
        logic scan;   // take the flag from the neighbor toward the start end
        logic apply;  // perform the sorted insert shift
        logic push;   // write at the first free slot
        logic pop;    // shift everything toward the service end
    } cell_ctrl_t;

    // Where a slot stands relative to the fill level
    typedef struct packed {
        logic occupied;
        logic at_count;
    } cell_pos_t;

endpackage

[hdl/mkpq_cell.sv]
// One slot of the ordered chain. Slot 0 sits at the service end.
module mkpq_cell (
    input  logic                   aclk,
    input  mkpq_pkg::cell_ctrl_t   ctrl,
    input  mkpq_pkg::cell_pos_t    pos,
    input  logic signed [31:0]     new_key,
    input  logic [31:0]            new_payload,
    input  logic signed [31:0]     up_key,
    input  logic [31:0]            up_payload,
    input  logic                   up_scan,
    input  logic signed [31:0]     dn_key,
    input  logic [31:0]            dn_payload,
    input  logic                   dn_scan,
    output logic signed [31:0]     key_q,
    output logic [31:0]            payload_q,
    output logic                   scan_q
);

    logic signed [31:0] key_reg, key_next;
    logic [31:0]        payload_reg, payload_next;
    logic               scan_reg, scan_next;
    logic               le;

    // Scan flag: set when this slot or one nearer the start end holds a key <= new key
    always_comb begin
        le = pos.occupied && (key_reg <= new_key);
        scan_next = scan_reg;
        if (ctrl.load) begin
            scan_next = le;
        end else if (ctrl.scan) begin
            scan_next = scan_reg | up_scan;
        end
    end

    // Data movement
    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        priority if (ctrl.pop) begin
            key_next     = up_key;
            payload_next = up_payload;
        end else if (ctrl.push) begin
            if (pos.at_count) begin
                key_next     = new_key;
                payload_next = new_payload;
            end
        end else if (ctrl.apply) begin
            // slots at or below the insert point keep their entry
            if (!scan_reg) begin
                if (dn_scan) begin
                    key_next     = new_key;
                    payload_next = new_payload;
                end else begin
                    key_next     = dn_key;
                    payload_next = dn_payload;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        scan_reg    <= scan_next;
    end

    assign key_q     = key_reg;
    assign payload_q = payload_reg;
    assign scan_q    = scan_reg;

endmodule

[hdl/min_key_priority_queue_top.sv]
// Bounded priority queue of (key, payload) entries held in a chain of DEPTH slots,
// slot 0 at the service end. Every operation returns exactly one result. Pop, push to
// the start end and clear are answered from the idle state. A sorted insert goes from idle
// straight to the apply state while the queue holds at most one entry, and through the
// scan state first otherwise: the flag that marks where the new entry belongs ripples
// one slot per cycle through the chain before all slots shift together. Inserts and
// pushes into a full queue are dropped with status full; no start-up pass is needed.
module min_key_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mkpq_pkg::in_item_t    s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mkpq_pkg::out_item_t   m_payload
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       scan_cnt_reg, scan_cnt_next;
    mkpq_pkg::in_item_t  hold_reg, hold_next;
    logic                m_valid_reg, m_valid_next;
    mkpq_pkg::out_item_t m_data_reg, m_data_next;

    mkpq_pkg::cell_ctrl_t ctrl;
    mkpq_pkg::in_item_t   new_item;
    logic                 accept;
    logic                 is_full;
    logic                 is_empty;

    logic signed [31:0] slot_key     [DEPTH];
    logic [31:0]        slot_payload [DEPTH];
    logic               slot_scan    [DEPTH];

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign new_item = (state_reg == ST_IDLE) ? s_payload : hold_reg;

    // Commands to the chain
    always_comb begin
        ctrl = '0;
        if (accept) begin
            unique case (s_payload.kind)
                mkpq_pkg::KIND_INSERT: ctrl.load = !is_full;
                mkpq_pkg::KIND_PUSH:   ctrl.push = !is_full;
                mkpq_pkg::KIND_POP:    ctrl.pop  = !is_empty;
                mkpq_pkg::KIND_CLEAR:  ctrl      = '0;
            endcase
        end
        if (state_reg == ST_SCAN) begin
            ctrl.scan = 1'b1;
        end
        if (state_reg == ST_APPLY) begin
            ctrl.apply = 1'b1;
        end
    end

    // Slot chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        mkpq_pkg::cell_pos_t pos;
        logic signed [31:0]  up_key, dn_key;
        logic [31:0]         up_payload, dn_payload;
        logic                up_scan, dn_scan;

        assign pos.occupied = (CW'(i) < count_reg);
        assign pos.at_count = (CW'(i) == count_reg);

        if (i == DEPTH - 1) begin : g_top
            assign up_key     = '0;
            assign up_payload = '0;
            assign up_scan    = 1'b0;
        end else begin : g_mid
            assign up_key     = slot_key[i+1];
            assign up_payload = slot_payload[i+1];
            assign up_scan    = slot_scan[i+1];
        end

        if (i == 0) begin : g_svc
            // nothing below: the new entry lands here when no slot keeps its place
            assign dn_key     = '0;
            assign dn_payload = '0;
            assign dn_scan    = 1'b1;
        end else begin : g_lower
            assign dn_key     = slot_key[i-1];
            assign dn_payload = slot_payload[i-1];
            assign dn_scan    = slot_scan[i-1];
        end

        mkpq_cell u_slot (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .pos         (pos),
            .new_key     (new_item.key_in),
            .new_payload (new_item.payload_in),
            .up_key      (up_key),
            .up_payload  (up_payload),
            .up_scan     (up_scan),
            .dn_key      (dn_key),
            .dn_payload  (dn_payload),
            .dn_scan     (dn_scan),
            .key_q       (slot_key[i]),
            .payload_q   (slot_payload[i]),
            .scan_q      (slot_scan[i])
        );
    end

    // Sequencer and result register
    always_comb begin
        mkpq_pkg::out_item_t res;
        logic                emit;
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        hold_next     = hold_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        res           = '0;
        emit          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_payload.kind)
                        mkpq_pkg::KIND_INSERT: begin
                            if (is_full) begin
                                res.status = mkpq_pkg::STATUS_FULL;
                                emit       = 1'b1;
                            end else begin
                                hold_next = s_payload;
                                if (count_reg <= CW'(1)) begin
                                    state_next = ST_APPLY;
                                end else begin
                                    scan_cnt_next = count_reg - CW'(1);
                                    state_next    = ST_SCAN;
                                end
                            end
                        end
                        mkpq_pkg::KIND_PUSH: begin
                            if (is_full) begin
                                res.status = mkpq_pkg::STATUS_FULL;
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                            emit = 1'b1;
                        end
                        mkpq_pkg::KIND_POP: begin
                            if (is_empty) begin
                                res.status = mkpq_pkg::STATUS_EMPTY;
                            end else begin
                                res.key_out     = slot_key[0];
                                res.payload_out = slot_payload[0];
                                count_next      = count_reg - CW'(1);
                            end
                            emit = 1'b1;
                        end
                        mkpq_pkg::KIND_CLEAR: begin
                            count_next = '0;
                            emit       = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg == CW'(1)) begin
                    state_next = ST_APPLY;
                end else begin
                    scan_cnt_next = scan_cnt_reg - CW'(1);
                end
            end
            ST_APPLY: begin
                count_next = count_reg + CW'(1);
                emit       = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            res.occupancy = 5'(count_next);
            m_valid_next  = 1'b1;
            m_data_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg <= scan_cnt_next;
        hold_reg     <= hold_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

endmodule

[hdl/mkpq_checker.sv]
`include "min_key_priority_queue_top_macros.svh"

// Port-level checks on the priority queue
module mkpq_checker #(
    parameter int DEPTH = 16
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mkpq_pkg::in_item_t  s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input mkpq_pkg::out_item_t m_payload
);

    logic s_fire;
    logic err_result;

    assign s_fire     = s_valid && s_ready && (s_payload.kind == mkpq_pkg::KIND_CLEAR);
    assign err_result = m_valid && (m_payload.status != mkpq_pkg::STATUS_OK);

    // a stalled result holds
    `MKPQ_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_payload), "result changed while stalled")
    // only a successful pop carries data
    `MKPQ_ASSERT_NOW(a_err_no_data, err_result, (m_payload.key_out == 0) && (m_payload.payload_out == 0), "error result carries data")
    // a dropped item means the queue is at capacity
    `MKPQ_ASSERT_NOW(a_full_occ, m_valid && (m_payload.status == mkpq_pkg::STATUS_FULL), m_payload.occupancy == 5'(DEPTH), "full status with wrong occupancy")
    // an empty pop leaves nothing behind
    `MKPQ_ASSERT_NOW(a_empty_occ, m_valid && (m_payload.status == mkpq_pkg::STATUS_EMPTY), m_payload.occupancy == 5'd0, "empty status with entries held")
    // a clear is answered next cycle with an empty queue
    `MKPQ_ASSERT_NEXT(a_clear_result, s_fire, m_valid && (m_payload.occupancy == 5'd0), "clear not answered with empty queue")

endmodule

bind min_key_priority_queue_top mkpq_checker #(.DEPTH(DEPTH)) u_mkpq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
